// ----- rtl/rlew_word_run_decoder_macros.svh -----
// Assertion macros for the run-length word decoder
`ifndef RLEW_WORD_RUN_DECODER_MACROS_SVH
`define RLEW_WORD_RUN_DECODER_MACROS_SVH

// same-cycle implication
`define RLEW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RLEW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/rlew_pkg.sv -----
package rlew_pkg;

   localparam int WORD_W = 16;
   localparam int SIDE_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int MAX_SIDE_DEFAULT = 64;
   localparam logic [WORD_W-1:0] TAG_DEFAULT = 16'hABCD;
   localparam logic [SIDE_W-1:0] SIDE_DEFAULT = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_TAG_WORD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT = 2'd2;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_COUNT = 2'd2;
   localparam logic [1:0] PH_VALUE = 2'd3;

   localparam logic REQ_WORD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic req_type;
      logic [WORD_W-1:0] data_word;
      logic last_word;
   } rlew_req_type;

   typedef struct packed {
      logic out_valid;
      logic [WORD_W-1:0] out_word;
      logic refused;
      logic plane_done;
      logic size_error;
   } rlew_rsp_type;

endpackage

// ----- rtl/rlew_word_run_decoder.sv -----
// Run-length word decoder, one plane of 16-bit words.
// The response is registered and is valid in the cycle after a request is accepted.
// Throughput: one request per cycle while rsp_ready is high or no response is pending;
// a single combinational pass between the state registers and the response register sets this figure.
// Reset (synchronous, active high) returns the phase, run and word count to
// their start values and loads the registers with their defaults.
module rlew_word_run_decoder
   import rlew_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  rlew_req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rlew_rsp_type rsp_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0] csr_data
);

   logic [WORD_W-1:0] tag_word_ff;
   logic [SIDE_W-1:0] plane_width_ff;
   logic [SIDE_W-1:0] plane_height_ff;

   logic [1:0] phase_ff, phase_in;
   logic [WORD_W-1:0] run_value_ff, run_value_in;
   logic [WORD_W-1:0] run_left_ff, run_left_in;
   logic [WORD_W-1:0] words_made_ff, words_made_in;
   logic end_seen_ff, end_seen_in;

   logic rsp_valid_ff;
   rlew_rsp_type rsp_payload_ff, rsp_payload_in;

   logic [SIDE_W-1:0] width_clamped, height_clamped;
   logic [2*SIDE_W-1:0] expect_words;
   logic [WORD_W-1:0] words_inc;
   logic req_accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign width_clamped = (32'(plane_width_ff) > MAX_SIDE) ? SIDE_W'(MAX_SIDE)
                                                            : plane_width_ff;
   assign height_clamped = (32'(plane_height_ff) > MAX_SIDE) ? SIDE_W'(MAX_SIDE)
                                                              : plane_height_ff;
   assign expect_words = (2*SIDE_W)'(width_clamped) * (2*SIDE_W)'(height_clamped);
   assign words_inc = (words_made_ff == '1) ? words_made_ff : words_made_ff + WORD_W'(1);

   always_comb begin
      logic done;
      logic forced;
      logic [WORD_W-1:0] words_chk;
      done = 1'b0;
      forced = 1'b0;
      words_chk = words_made_ff;
      phase_in = phase_ff;
      run_value_in = run_value_ff;
      run_left_in = run_left_ff;
      words_made_in = words_made_ff;
      end_seen_in = end_seen_ff;
      rsp_payload_in = '0;

      if (req_payload.req_type == REQ_TICK) begin
         if (run_left_ff != '0) begin
            rsp_payload_in.out_valid = 1'b1;
            rsp_payload_in.out_word = run_value_ff;
            run_left_in = run_left_ff - WORD_W'(1);
            words_made_in = words_inc;
            words_chk = words_inc;
            done = (run_left_ff == WORD_W'(1)) && end_seen_ff;
         end
      end else if (run_left_ff != '0) begin
         rsp_payload_in.refused = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               phase_in = PH_DATA;
               done = req_payload.last_word;
            end
            PH_DATA: begin
               if (req_payload.data_word == tag_word_ff) begin
                  phase_in = PH_COUNT;
                  done = req_payload.last_word;
                  forced = 1'b1;
               end else begin
                  rsp_payload_in.out_valid = 1'b1;
                  rsp_payload_in.out_word = req_payload.data_word;
                  words_made_in = words_inc;
                  words_chk = words_inc;
                  done = req_payload.last_word;
               end
            end
            PH_COUNT: begin
               phase_in = PH_VALUE;
               if (req_payload.last_word) begin
                  run_left_in = '0;
                  done = 1'b1;
                  forced = 1'b1;
               end else begin
                  run_left_in = req_payload.data_word;
               end
            end
            PH_VALUE: begin
               run_value_in = req_payload.data_word;
               phase_in = PH_DATA;
               if (req_payload.last_word) begin
                  if (run_left_ff != '0) begin
                     end_seen_in = 1'b1;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end

      if (done) begin
         rsp_payload_in.plane_done = 1'b1;
         rsp_payload_in.size_error = forced || (words_chk != WORD_W'(expect_words));
         phase_in = PH_HEADER;
         words_made_in = '0;
         end_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_word_ff <= TAG_DEFAULT;
         plane_width_ff <= SIDE_DEFAULT;
         plane_height_ff <= SIDE_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         priority if (csr_index == CSR_TAG_WORD) begin
            tag_word_ff <= csr_data;
         end else if (csr_index == CSR_PLANE_WIDTH) begin
            plane_width_ff <= csr_data[SIDE_W-1:0];
         end else if (csr_index == CSR_PLANE_HEIGHT) begin
            plane_height_ff <= csr_data[SIDE_W-1:0];
         end else begin
            tag_word_ff <= tag_word_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         run_value_ff <= '0;
         run_left_ff <= '0;
         words_made_ff <= '0;
         end_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
            run_value_ff <= run_value_in;
            run_left_ff <= run_left_in;
            words_made_ff <= words_made_in;
            end_seen_ff <= end_seen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// ----- rtl/rlew_port_chk.sv -----
`include "rlew_word_run_decoder_macros.svh"

module rlew_port_chk
   import rlew_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input rlew_req_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input rlew_rsp_type rsp_payload,
   input logic csr_valid,
   input logic csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [WORD_W-1:0] csr_data
);

   logic rsp_stall;
   logic rsp_error;
   logic rsp_refused;
   logic rsp_quiet;
   logic rsp_empty;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_error = rsp_valid && rsp_payload.size_error;
   assign rsp_refused = rsp_valid && rsp_payload.refused;
   assign rsp_quiet = !rsp_payload.out_valid && !rsp_payload.plane_done;
   assign rsp_empty = rsp_valid && !rsp_payload.out_valid;

   // a response that is held must not change
   `RLEW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))
   // every accepted request yields a response in the next cycle
   `RLEW_ASSERT_NEXT(a_req_rsp, clock, reset, req_valid && req_ready, rsp_valid)
   `RLEW_ASSERT_NOW(a_err_done, clock, reset, rsp_error, rsp_payload.plane_done)
   `RLEW_ASSERT_NOW(a_refused, clock, reset, rsp_refused, rsp_quiet)
   `RLEW_ASSERT_NOW(a_word_zero, clock, reset, rsp_empty, rsp_payload.out_word == '0)

endmodule

bind rlew_word_run_decoder rlew_port_chk u_rlew_port_chk (.*);
